### hdl/vfcm_pkg.sv
// Shared types, constants and helper functions for the voxel face culling mesher.
// Depends on nothing; every other file of the block imports it.
package vfcm_pkg;

  localparam int CHUNK_DIM   = 16;
  localparam int FACES       = 6;
  localparam int COORD_W     = 4;
  localparam int ID_W        = 16;
  localparam int SEC_W       = 2;
  localparam int TEX_W       = 8;
  localparam int TEXS_W      = FACES * TEX_W;
  localparam int FACE_W      = 3;
  localparam int COUNT_W     = 17;
  localparam int LIGHT_W     = 9;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COUNT_W-1:0] MAX_COUNT = {COUNT_W{1'b1}};

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_VACUUM_ID   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT = 1'b1;

  typedef struct packed {
    logic                     clear;
    logic [FACES-1:0]         mask;
    logic [SEC_W-1:0]         section;
    logic [COORD_W-1:0]       x;
    logic [COORD_W-1:0]       y;
    logic [COORD_W-1:0]       z;
    logic [TEXS_W-1:0]        textures;
  } entry_t;

  typedef struct packed {
    logic [FACE_W-1:0]        face;
    logic [SEC_W-1:0]         section;
    logic [COUNT_W-1:0]       base_vertex;
    logic [COORD_W-1:0]       x;
    logic [COORD_W-1:0]       y;
    logic [COORD_W-1:0]       z;
    logic [TEX_W-1:0]         texture;
    logic [LIGHT_W-1:0]       light;
    logic                     overflow;
    logic                     last;
  } quad_t;

  function automatic logic [FACE_W-1:0] lowest_face(input logic [FACES-1:0] mask);
    logic [FACE_W-1:0] f;
    logic              found;
    f     = '0;
    found = 1'b0;
    for (int i = 0; i < FACES; i++) begin
      if (mask[i] && !found) begin
        f     = FACE_W'(i);
        found = 1'b1;
      end
    end
    return f;
  endfunction

  function automatic logic [LIGHT_W-1:0] face_light(input logic [FACE_W-1:0] f);
    logic [LIGHT_W-1:0] l;
    case (f)
      3'd0: begin
        l = 9'd218;
      end
      3'd1: begin
        l = 9'd243;
      end
      3'd2: begin
        l = 9'd205;
      end
      3'd3: begin
        l = 9'd230;
      end
      3'd4: begin
        l = 9'd192;
      end
      default: begin
        l = 9'd256;
      end
    endcase
    return l;
  endfunction

endpackage

### hdl/vfcm_front.sv
// Front end: accepts voxel beats, drops voxels that give nothing and works out which faces show.
// Depends on vfcm_pkg; feeds vfcm_queue.
module vfcm_front #(
  parameter int NUM_SECTIONS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        chunk_start,
  input  logic [vfcm_pkg::COORD_W-1:0] vox_x,
  input  logic [vfcm_pkg::COORD_W-1:0] vox_y,
  input  logic [vfcm_pkg::COORD_W-1:0] vox_z,
  input  logic [vfcm_pkg::ID_W-1:0]    block_id,
  input  logic [vfcm_pkg::SEC_W-1:0]   block_section,
  input  logic [vfcm_pkg::TEXS_W-1:0]  face_textures,
  input  logic [vfcm_pkg::FACES-1:0]   neighbour_vacuum,
  input  logic [2*vfcm_pkg::FACES-1:0] neighbour_sections,
  input  logic [vfcm_pkg::ID_W-1:0]    vacuum_id,
  input  logic [vfcm_pkg::SEC_W-1:0]   transparent_section,
  output logic                        push,
  output vfcm_pkg::entry_t            push_entry,
  input  logic                        full
);
  import vfcm_pkg::*;

  logic             skip;
  logic [FACES-1:0] shown;
  logic             seen_r;

  always_comb begin
    for (int f = 0; f < FACES; f++) begin
      if (!neighbour_vacuum[f]) begin
        shown[f] = !((block_section == transparent_section) ||
                     (neighbour_sections[2*f +: 2] == block_section));
      end else begin
        shown[f] = 1'b1;
      end
    end
  end

  assign skip = (block_id == vacuum_id) ||
                (32'(block_section) >= NUM_SECTIONS) ||
                (32'(vox_x) >= CHUNK_DIM) ||
                (32'(vox_y) >= CHUNK_DIM) ||
                (32'(vox_z) >= CHUNK_DIM);

  assign in_ready = !full && seen_r;

  always_comb begin
    push_entry.clear    = chunk_start;
    push_entry.mask     = skip ? '0 : shown;
    push_entry.section  = block_section;
    push_entry.x        = vox_x;
    push_entry.y        = vox_y;
    push_entry.z        = vox_z;
    push_entry.textures = face_textures;
  end

  // Beats that clear nothing and show no face need not reach the back end.
  assign push = in_valid && in_ready && (chunk_start || (|push_entry.mask));

  // Holds off input beats until the cycle after reset is released.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= 1'b1;
    end
  end

endmodule

### hdl/vfcm_queue.sv
// Short first-in first-out queue of classified voxels between the front and back ends.
// Depends on vfcm_pkg for the entry type and depth.
module vfcm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  vfcm_pkg::entry_t push_entry,
  output logic             full,
  output logic             head_valid,
  output vfcm_pkg::entry_t head_entry,
  input  logic             pop
);
  import vfcm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### hdl/vfcm_back.sv
// Back end: walks one voxel's shown faces, one quad a cycle unless out_ready stalls, keeps the
// section vertex counters and holds the result register. Depends on vfcm_pkg; fed by vfcm_queue.
module vfcm_back #(
  parameter int NUM_SECTIONS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  vfcm_pkg::entry_t head_entry,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output vfcm_pkg::quad_t  out_quad
);
  import vfcm_pkg::*;

  localparam int SIDX_W = $clog2(NUM_SECTIONS);

  logic [COUNT_W-1:0] count_r [NUM_SECTIONS];
  entry_t             cur_r;
  logic [FACES-1:0]   mask_r;
  logic [FACES-1:0]   mask_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  quad_t              quad_r;
  quad_t              quad_nxt;

  logic               advance;
  logic               emit;
  logic               load;
  logic [FACE_W-1:0]  f;
  logic [FACES-1:0]   rest;
  logic [SIDX_W-1:0]  sidx;
  logic [COUNT_W-1:0] cnt;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] cnt_nxt;

  assign advance = !out_valid_r || out_ready;
  assign emit    = (|mask_r) && advance;
  assign f       = lowest_face(mask_r);
  assign rest    = mask_r & (mask_r - 1'b1);
  assign load    = head_valid && (!(|mask_r) || (emit && (rest == '0)));
  assign pop     = load;

  assign sidx    = SIDX_W'(cur_r.section);
  assign cnt     = count_r[sidx];
  assign sum     = {1'b0, cnt} + (COUNT_W + 1)'(4);
  assign cnt_nxt = (sum > {1'b0, MAX_COUNT}) ? MAX_COUNT : sum[COUNT_W-1:0];

  always_comb begin
    mask_nxt = mask_r;
    if (load) begin
      mask_nxt = head_entry.mask;
    end else if (emit) begin
      mask_nxt = rest;
    end
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    quad_nxt             = quad_r;
    if (emit) begin
      quad_nxt.face        = f;
      quad_nxt.section     = cur_r.section;
      quad_nxt.base_vertex = cnt;
      quad_nxt.x           = cur_r.x;
      quad_nxt.y           = cur_r.y;
      quad_nxt.z           = cur_r.z;
      quad_nxt.texture     = cur_r.textures[{f, 3'b000} +: TEX_W];
      quad_nxt.light       = face_light(f);
      quad_nxt.overflow    = (cnt > (MAX_COUNT - COUNT_W'(3)));
      quad_nxt.last        = (rest == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= head_entry;
    end
    quad_r <= quad_nxt;
  end

  // A chunk start takes effect when its voxel is loaded, after the previous voxel's last quad.
  always_ff @(posedge clk) begin
    if (!rst_n || (load && head_entry.clear)) begin
      for (int i = 0; i < NUM_SECTIONS; i++) begin
        count_r[i] <= '0;
      end
    end else if (emit) begin
      count_r[sidx] <= cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_quad  = quad_r;

endmodule

### hdl/voxel_face_culling_mesher.sv
// Top level of the voxel face culling mesher: stream ports, configuration registers and the
// front end, queue and back end. Depends on vfcm_pkg, vfcm_front, vfcm_queue and vfcm_back.
//
// One voxel enters per beat and gives zero to six quad beats, one per shown face in the order
// -x, +x, -y, +y, -z, +z, with the last quad of a voxel marked by out_tlast. The back end emits
// one quad a cycle while out_tready does not stall it, and holds a voxel until the quad of its
// last shown face is emitted. Voxels that show nothing and start no chunk are dropped by the
// front end, which takes one beat a cycle while the queue has room; a chunk start that shows
// nothing is still loaded by the back end. When the back end is idle, an accepted beat passes
// through the queue and the back end's current-voxel registers before its first quad is offered
// from the result register. A two-entry queue lets new voxels be taken while a result waits on
// out_tready. Vertex bases are counted per section and saturate with the overflow flag set.
module voxel_face_culling_mesher #(
  parameter int NUM_SECTIONS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // x[3:0], y[7:4], z[11:8], block_id[27:12], block_section[29:28],
  // face_textures[77:30], neighbour_vacuum[83:78], neighbour_sections[95:84]
  input  logic [vfcm_pkg::IN_DATA_W-1:0]    in_tdata,
  // chunk_start[0]
  input  logic                              in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // face[2:0], out_section[4:3], base_vertex[21:5], quad_x[25:22], quad_y[29:26],
  // quad_z[33:30], texture[41:34], light[50:42], overflow[51], zero[55:52]
  output logic [vfcm_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_wen,
  input  logic [vfcm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vfcm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import vfcm_pkg::*;

  logic [ID_W-1:0]  vacuum_id_r;
  logic [SEC_W-1:0] transparent_section_r;
  logic             push;
  entry_t           push_entry;
  logic             full;
  logic             head_valid;
  entry_t           head_entry;
  logic             pop;
  quad_t            quad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vacuum_id_r           <= '0;
      transparent_section_r <= SEC_W'(1);
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_VACUUM_ID: begin
          vacuum_id_r <= cfg_wdata[ID_W-1:0];
        end
        REG_TRANSPARENT: begin
          transparent_section_r <= cfg_wdata[SEC_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  vfcm_front #(
    .NUM_SECTIONS(NUM_SECTIONS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_tvalid),
    .in_ready           (in_tready),
    .chunk_start        (in_tuser),
    .vox_x              (in_tdata[3:0]),
    .vox_y              (in_tdata[7:4]),
    .vox_z              (in_tdata[11:8]),
    .block_id           (in_tdata[27:12]),
    .block_section      (in_tdata[29:28]),
    .face_textures      (in_tdata[77:30]),
    .neighbour_vacuum   (in_tdata[83:78]),
    .neighbour_sections (in_tdata[95:84]),
    .vacuum_id          (vacuum_id_r),
    .transparent_section(transparent_section_r),
    .push               (push),
    .push_entry         (push_entry),
    .full               (full)
  );

  vfcm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop)
  );

  vfcm_back #(
    .NUM_SECTIONS(NUM_SECTIONS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_quad   (quad)
  );

  assign out_tdata = {4'b0000, quad.overflow, quad.light, quad.texture, quad.z, quad.y,
                      quad.x, quad.base_vertex, quad.section, quad.face};
  assign out_tlast = quad.last;

endmodule
